FILE: design/rnsh_pkg.sv
package rnsh_pkg;

   // Defaults for the top-level parameters.
   localparam int MAX_SEGMENTS_DEFAULT = 256;
   localparam int COORD_BITS_DEFAULT   = 24;

   // Fixed field widths of the two channels, and the fraction width.
   localparam int FIELD_W   = 24;
   localparam int FRAC_BITS = 32;
   localparam int DIST_W    = 24;

   localparam logic [DIST_W-1:0] MAX_DISTANCE = 24'hFFFFFF;

   // Operation codes.
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_RAY  = 1'b1;

   // Register indexes, as selected by the word address of the register port.
   localparam logic REG_SEGMENT_COUNT = 1'b0;
   localparam logic REG_DIST_LIMIT    = 1'b1;

   typedef struct packed {
      logic                      op;
      logic [7:0]                seg_index;
      logic signed [FIELD_W-1:0] start_x;
      logic signed [FIELD_W-1:0] start_y;
      logic signed [FIELD_W-1:0] end_x;
      logic signed [FIELD_W-1:0] end_y;
      logic [7:0]                object_id;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic [DIST_W-1:0] hit_distance;
      logic [7:0]        hit_object;
      logic [DIST_W-1:0] texture_offset;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DIFF,
      ST_CROSS,
      ST_TEST,
      ST_DIV,
      ST_MUL,
      ST_DIST,
      ST_TEX,
      ST_NEXT
   } state_type;

endpackage

FILE: design/ray_nearest_segment_hit.sv
// Nearest crossing of a ray with a table of wall segments.
//
// Input channel: an item is taken at a rising edge where start is high and busy
// is low. An op 0 beat loads one wall (endpoints and object number) into the
// wall memory at seg_index; it is written at that edge, busy stays low and no
// result follows. An op 1 beat casts a ray and, unless the segment count is
// zero, raises busy until its result has been issued.
// Result channel: one beat per ray, shown for exactly one cycle with
// rsp_strobe high. The receiver cannot hold it off and must take it then.
// Register port: segment_count at byte address 0, the distance limit at 4;
// writes complete in the access cycle, pready is always high.
// Sequence: a ray with a zero count answers in the next cycle. Otherwise each
// wall costs a memory read, the operand differences and four cross products
// on the shared multiplier; a crossing adds a fraction divide, multiplier
// steps and one or two square roots. The walk over the walls is strictly
// serial. Reset returns the sequencer to idle and sets the registers to a
// zero count and the largest distance; wall memory is not cleared and must
// be loaded before it is tested.
module ray_nearest_segment_hit
   import rnsh_pkg::*;
#(
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEFAULT,
   parameter int COORD_BITS   = COORD_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_strobe,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int C      = COORD_BITS;
   localparam int IDX_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
   localparam int ENT_W  = 4 * C + 8;
   localparam int MA     = C + 3;
   localparam int MB     = (C + 3 > FRAC_BITS + 1) ? C + 3 : FRAC_BITS + 1;
   localparam int PW     = MA + MB;
   localparam int SQ_W   = 2 * C + 4;
   localparam int ROOT_W = SQ_W / 2;

   // Register file.
   logic [8:0]        seg_count_ff;
   logic [DIST_W-1:0] max_dist_ff;
   logic              csr_write;

   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == REG_DIST_LIMIT) ? 32'(max_dist_ff) : 32'(seg_count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_count_ff <= '0;
         max_dist_ff  <= MAX_DISTANCE;
      end else if (csr_write) begin
         if (paddr[2] == REG_SEGMENT_COUNT) begin
            seg_count_ff <= pwdata[8:0];
         end else begin
            max_dist_ff <= pwdata[DIST_W-1:0];
         end
      end
   end

   // Sequencer state.
   state_type        state_ff, state_in;
   logic [3:0]       step_ff;
   logic [CNT_W-1:0] seg_ff;
   logic [CNT_W-1:0] n_ff;
   logic [CNT_W-1:0] n_in;
   logic             accept;
   logic             load_ok;

   assign accept  = start && (state_ff == ST_IDLE);
   assign busy    = (state_ff != ST_IDLE);
   assign load_ok = 32'(req_data.seg_index) < MAX_SEGMENTS;
   assign n_in    = (32'(seg_count_ff) > MAX_SEGMENTS) ? CNT_W'(MAX_SEGMENTS)
                                                      : CNT_W'(seg_count_ff);

   // Wall memory: {start x, start y, end x, end y, object}.
   logic             mem_rd;
   logic [ENT_W-1:0] mem_rdata;
   logic signed [C-1:0] w_sx, w_sy, w_ex, w_ey;
   logic [7:0]       w_obj;

   rnsh_wall_mem #(
      .DEPTH (MAX_SEGMENTS),
      .WIDTH (ENT_W),
      .AW    (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (accept && req_data.op == OP_LOAD && load_ok),
      .wr_addr (IDX_W'(req_data.seg_index)),
      .wr_data ({C'(req_data.start_x[FIELD_W-1:0]), C'(req_data.start_y[FIELD_W-1:0]),
                 C'(req_data.end_x[FIELD_W-1:0]), C'(req_data.end_y[FIELD_W-1:0]),
                 req_data.object_id}),
      .rd_en   (mem_rd),
      .rd_addr (seg_ff[IDX_W-1:0]),
      .rd_data (mem_rdata)
   );

   assign {w_sx, w_sy, w_ex, w_ey, w_obj} = mem_rdata;

   // Ray registers.
   logic signed [C-1:0] sx_ff, sy_ff, ex_ff, ey_ff;
   logic signed [C:0]   d1x_ff, d1y_ff;
   logic [C:0]          d1x_mag, d1y_mag;
   logic signed [C-1:0] sx_in, sy_in, ex_in, ey_in;

   assign sx_in   = C'(req_data.start_x[FIELD_W-1:0]);
   assign sy_in   = C'(req_data.start_y[FIELD_W-1:0]);
   assign ex_in   = C'(req_data.end_x[FIELD_W-1:0]);
   assign ey_in   = C'(req_data.end_y[FIELD_W-1:0]);
   assign d1x_mag = d1x_ff[C] ? (C+1)'(-d1x_ff) : d1x_ff;
   assign d1y_mag = d1y_ff[C] ? (C+1)'(-d1y_ff) : d1y_ff;

   // Per-wall operand differences.
   logic signed [C:0] a1_ff, a2_ff, b1_ff, b2_ff, c1_ff, c2_ff, d2x_ff, d2y_ff;

   // Shared multiplier with a registered product.
   logic signed [MA-1:0] mul_a;
   logic signed [MB-1:0] mul_b;
   logic signed [PW-1:0] prod_ff;
   logic signed [PW-1:0] hold_ff;
   logic signed [PW-1:0] cross_ff [4];

   always_ff @(posedge clock) begin
      prod_ff <= PW'(mul_a) * PW'(mul_b);
   end

   // Crossing test and magnitudes of the wall-side cross products.
   logic          p_opp, q_opp;
   logic [PW-1:0] q1_mag, q2_mag;

   function automatic logic opposite(input logic signed [PW-1:0] a,
                                     input logic signed [PW-1:0] b);
      opposite = (a != '0) && (b != '0) && (a[PW-1] != b[PW-1]);
   endfunction

   assign p_opp  = opposite(cross_ff[0], cross_ff[1]);
   assign q_opp  = opposite(cross_ff[2], cross_ff[3]);
   assign q1_mag = cross_ff[2][PW-1] ? PW'(-cross_ff[2]) : PW'(cross_ff[2]);
   assign q2_mag = cross_ff[3][PW-1] ? PW'(-cross_ff[3]) : PW'(cross_ff[3]);

   // Fraction divider.
   logic                 div_start, div_done;
   logic [FRAC_BITS-1:0] div_q;
   logic [FRAC_BITS-1:0] t_ff;

   rnsh_div #(.W(PW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (q1_mag),
      .divisor  (q1_mag + q2_mag),
      .done     (div_done),
      .quotient (div_q)
   );

   // Hit point offsets from ray start and from wall start.
   logic signed [C+2:0] ox_ff, oy_ff, hx_ff, hy_ff;
   logic signed [C+2:0] off_val;
   logic [C+2:0]        off_mag;

   assign off_mag = prod_ff[FRAC_BITS +: C+3];

   always_comb begin
      if (step_ff == 4'd1) begin
         off_val = d1x_ff[C] ? -$signed(off_mag) : $signed(off_mag);
      end else begin
         off_val = d1y_ff[C] ? -$signed(off_mag) : $signed(off_mag);
      end
   end

   // Square roots for the two lengths.
   logic [SQ_W-1:0]   dsq_ff, tsq_ff;
   logic              sq_start, sq_done;
   logic [ROOT_W-1:0] sq_root;
   logic [DIST_W-1:0] root_sat;

   rnsh_sqrt #(.W(SQ_W)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand ((state_ff == ST_TEX) ? tsq_ff : dsq_ff),
      .done     (sq_done),
      .root     (sq_root)
   );

   assign root_sat = (64'(sq_root) > 64'(MAX_DISTANCE)) ? MAX_DISTANCE : DIST_W'(sq_root);

   // Best hit so far.
   logic              found_ff;
   logic [DIST_W-1:0] best_ff, cand_ff, tex_ff;
   logic [7:0]        obj_ff;
   logic              closer;
   logic              last_wall;

   assign closer    = root_sat < best_ff;
   assign last_wall = (seg_ff + 1'b1) == n_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.op == OP_RAY && n_in != '0) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: state_in = ST_DIFF;
         ST_DIFF:  state_in = ST_CROSS;
         ST_CROSS: begin
            if (step_ff == 4'd8) begin
               state_in = ST_TEST;
            end
         end
         ST_TEST:  state_in = (p_opp && q_opp) ? ST_DIV : ST_NEXT;
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (step_ff == 4'd6) begin
               state_in = ST_DIST;
            end
         end
         ST_DIST: begin
            if (sq_done) begin
               state_in = closer ? ST_TEX : ST_NEXT;
            end
         end
         ST_TEX: begin
            if (sq_done) begin
               state_in = ST_NEXT;
            end
         end
         ST_NEXT:  state_in = last_wall ? ST_IDLE : ST_FETCH;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Control outputs and multiplier operands.
   always_comb begin
      mem_rd    = 1'b0;
      div_start = 1'b0;
      sq_start  = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      case (state_ff)
         ST_FETCH: mem_rd = 1'b1;
         ST_CROSS: begin
            case (step_ff)
               4'd0: begin mul_a = MA'(d1x_ff); mul_b = MB'(a2_ff); end
               4'd1: begin mul_a = MA'(d1y_ff); mul_b = MB'(a1_ff); end
               4'd2: begin mul_a = MA'(d1x_ff); mul_b = MB'(b2_ff); end
               4'd3: begin mul_a = MA'(d1y_ff); mul_b = MB'(b1_ff); end
               4'd4: begin mul_a = MA'(d2y_ff); mul_b = MB'(a1_ff); end
               4'd5: begin mul_a = MA'(d2x_ff); mul_b = MB'(a2_ff); end
               4'd6: begin mul_a = MA'(d2x_ff); mul_b = MB'(c2_ff); end
               4'd7: begin mul_a = MA'(d2y_ff); mul_b = MB'(c1_ff); end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
         end
         ST_DIV:   div_start = (step_ff == 4'd0);
         ST_MUL: begin
            case (step_ff)
               4'd0: begin
                  mul_a = MA'($signed({1'b0, d1x_mag}));
                  mul_b = MB'($signed({1'b0, t_ff}));
               end
               4'd1: begin
                  mul_a = MA'($signed({1'b0, d1y_mag}));
                  mul_b = MB'($signed({1'b0, t_ff}));
               end
               4'd2: begin mul_a = ox_ff; mul_b = MB'(ox_ff); end
               4'd3: begin mul_a = oy_ff; mul_b = MB'(oy_ff); end
               4'd4: begin mul_a = hx_ff; mul_b = MB'(hx_ff); end
               4'd5: begin mul_a = hy_ff; mul_b = MB'(hy_ff); end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
         end
         ST_DIST:  sq_start = (step_ff == 4'd0);
         ST_TEX:   sq_start = (step_ff == 4'd0);
         default: begin
            mem_rd = 1'b0;
         end
      endcase
   end

   // Control registers. The step count holds at its top value, so that a long
   // divide or square root is started only once.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         step_ff    <= '0;
         rsp_strobe <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rsp_strobe <= 1'b0;
         if (state_in != state_ff) begin
            step_ff <= '0;
         end else if (step_ff != 4'hF) begin
            step_ff <= step_ff + 1'b1;
         end
         if ((state_ff == ST_IDLE && accept && req_data.op == OP_RAY && n_in == '0) ||
             (state_ff == ST_NEXT && last_wall)) begin
            rsp_strobe <= 1'b1;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.op == OP_RAY) begin
               sx_ff    <= sx_in;
               sy_ff    <= sy_in;
               ex_ff    <= ex_in;
               ey_ff    <= ey_in;
               d1x_ff   <= (C+1)'(ex_in) - (C+1)'(sx_in);
               d1y_ff   <= (C+1)'(ey_in) - (C+1)'(sy_in);
               n_ff     <= n_in;
               seg_ff   <= '0;
               found_ff <= 1'b0;
               best_ff  <= max_dist_ff;
               obj_ff   <= '0;
               tex_ff   <= '0;
            end
         end
         ST_DIFF: begin
            a1_ff  <= (C+1)'(w_sx) - (C+1)'(sx_ff);
            a2_ff  <= (C+1)'(w_sy) - (C+1)'(sy_ff);
            b1_ff  <= (C+1)'(w_ex) - (C+1)'(sx_ff);
            b2_ff  <= (C+1)'(w_ey) - (C+1)'(sy_ff);
            c1_ff  <= (C+1)'(ex_ff) - (C+1)'(w_sx);
            c2_ff  <= (C+1)'(ey_ff) - (C+1)'(w_sy);
            d2x_ff <= (C+1)'(w_ex) - (C+1)'(w_sx);
            d2y_ff <= (C+1)'(w_ey) - (C+1)'(w_sy);
         end
         ST_CROSS: begin
            // Products come out one step late: pair them up into cross products.
            if (step_ff[0]) begin
               hold_ff <= prod_ff;
            end else if (step_ff != 4'd0) begin
               cross_ff[step_ff[2:1] - 2'd1] <= hold_ff - prod_ff;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               t_ff <= div_q;
            end
         end
         ST_MUL: begin
            case (step_ff)
               4'd1: begin
                  ox_ff <= off_val;
                  hx_ff <= off_val - (C+3)'(a1_ff);
               end
               4'd2: begin
                  oy_ff <= off_val;
                  hy_ff <= off_val - (C+3)'(a2_ff);
               end
               4'd3: hold_ff <= prod_ff;
               4'd4: dsq_ff  <= SQ_W'(hold_ff + prod_ff);
               4'd5: hold_ff <= prod_ff;
               4'd6: tsq_ff  <= SQ_W'(hold_ff + prod_ff);
               default: hold_ff <= hold_ff;
            endcase
         end
         ST_DIST: begin
            if (sq_done) begin
               cand_ff <= root_sat;
            end
         end
         ST_TEX: begin
            if (sq_done) begin
               found_ff <= 1'b1;
               best_ff  <= cand_ff;
               tex_ff   <= root_sat;
               obj_ff   <= w_obj;
            end
         end
         ST_NEXT: begin
            seg_ff <= seg_ff + 1'b1;
         end
         default: begin
            seg_ff <= seg_ff;
         end
      endcase
   end

   // Result register; with no hit the object and offset stay at zero.
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE) begin
         rsp_data.hit            <= 1'b0;
         rsp_data.hit_distance   <= max_dist_ff;
         rsp_data.hit_object     <= '0;
         rsp_data.texture_offset <= '0;
      end else if (state_ff == ST_NEXT) begin
         rsp_data.hit            <= found_ff;
         rsp_data.hit_distance   <= best_ff;
         rsp_data.hit_object     <= obj_ff;
         rsp_data.texture_offset <= tex_ff;
      end
   end

endmodule

FILE: design/rnsh_wall_mem.sv
module rnsh_wall_mem
   import rnsh_pkg::*;
#(
   parameter int DEPTH = MAX_SEGMENTS_DEFAULT,
   parameter int WIDTH = 4 * COORD_BITS_DEFAULT + 8,
   parameter int AW    = 8
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/rnsh_div.sv
module rnsh_div
   import rnsh_pkg::*;
#(
   parameter int W = 60
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [W-1:0]         dividend,
   input  logic [W-1:0]         divisor,
   output logic                 done,
   output logic [FRAC_BITS-1:0] quotient
);

   localparam int CW = $clog2(FRAC_BITS + 1);

   // Restoring division, one quotient bit a cycle; the dividend is below the divisor.
   logic [W:0]           rem_ff;
   logic [W-1:0]         div_ff;
   logic [FRAC_BITS-1:0] quo_ff;
   logic [CW-1:0]        cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [W:0]           shifted;
   logic                 fits;

   assign shifted = {rem_ff[W-1:0], 1'b0};
   assign fits    = shifted >= {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(FRAC_BITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {1'b0, dividend};
         div_ff <= divisor;
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= fits ? (shifted - {1'b0, div_ff}) : shifted;
         quo_ff <= {quo_ff[FRAC_BITS-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: design/rnsh_sqrt.sv
module rnsh_sqrt
   import rnsh_pkg::*;
#(
   parameter int W = 52
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [W-1:0]   radicand,
   output logic           done,
   output logic [W/2-1:0] root
);

   localparam int H  = W / 2;
   localparam int CW = $clog2(H + 1);

   // Digit-by-digit square root, one root bit a cycle.
   logic [W-1:0]   rad_ff;
   logic [H+1:0]   rem_ff;
   logic [H-1:0]   root_ff;
   logic [CW-1:0]  cnt_ff;
   logic           busy_ff;
   logic           done_ff;
   logic [H+1:0]   rem_next;
   logic [H+1:0]   trial;
   logic           fits;

   assign rem_next = {rem_ff[H-1:0], rad_ff[W-1:W-2]};
   assign trial    = {root_ff, 2'b01};
   assign fits     = rem_next >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(H - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[W-3:0], 2'b00};
         rem_ff  <= fits ? (rem_next - trial) : rem_next;
         root_ff <= {root_ff[H-2:0], fits};
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

FILE: design/rnsh_checker.sv
module rnsh_checker
   import rnsh_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   // Nothing is issued straight after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("result beat right after reset");

   // A result beat always finds the block ready for the next item.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result beat while busy");

   // A load never makes the block busy.
   a_load_quick: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.op == OP_LOAD) |=> !busy)
      else $error("load held the block busy");

   // Busy only rises after a ray was taken.
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> ($past(start) && $past(req_data.op) == OP_RAY))
      else $error("busy rose without a ray");

   // A miss reports no object and no offset.
   a_miss_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.hit) |->
         (rsp_data.hit_object == '0 && rsp_data.texture_offset == '0))
      else $error("miss with object or offset set");

endmodule

bind ray_nearest_segment_hit rnsh_checker u_rnsh_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
